// File: hw/rtl/dhcprp_pkg.sv
// ----------------------------------------------------------------------------
// dhcprp_pkg
// Shared constants, codes and types of the DHCP reply parser.
// ----------------------------------------------------------------------------
package dhcprp_pkg;

   // Defaults of the top-level parameters
   localparam int COUNT_BITS_DEFAULT    = 16;
   localparam int HW_ADDR_BYTES_DEFAULT = 6;

   // Configuration register indexes
   localparam logic CSR_CLIENT_XID = 1'b0;
   localparam logic CSR_CLIENT_MAC = 1'b1;

   localparam int CSR_DATA_BITS = 48;

   localparam logic [31:0] CLIENT_XID_RESET = 32'h4C59_5244;
   localparam logic [47:0] CLIENT_MAC_RESET = 48'h0;

   // Datagram layout (offsets from the start of the UDP header)
   localparam int SRC_PORT_HI  = 0;
   localparam int SRC_PORT_LO  = 1;
   localparam int DST_PORT_HI  = 2;
   localparam int DST_PORT_LO  = 3;
   localparam int OP_OFFSET    = 8;
   localparam int XID_FIRST    = 12;
   localparam int XID_LAST     = 15;
   localparam int YIADDR_FIRST = 24;
   localparam int YIADDR_LAST  = 27;
   localparam int CHADDR_FIRST = 36;
   localparam int COOKIE_FIRST = 244;
   localparam int COOKIE_LAST  = 247;
   localparam int OPT_START    = 248;

   localparam logic [7:0]  SERVER_PORT  = 8'd67;
   localparam logic [7:0]  CLIENT_PORT  = 8'd68;
   localparam logic [7:0]  BOOTREPLY    = 8'd2;
   localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

   // Option codes
   localparam logic [7:0] OPT_PAD      = 8'd0;
   localparam logic [7:0] OPT_MASK     = 8'd1;
   localparam logic [7:0] OPT_ROUTER   = 8'd3;
   localparam logic [7:0] OPT_DNS      = 8'd6;
   localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
   localparam logic [7:0] OPT_SERVER   = 8'd54;
   localparam logic [7:0] OPT_END      = 8'd255;

   // Message types that are accepted
   localparam logic [7:0] MSG_OFFER = 8'd2;
   localparam logic [7:0] MSG_ACK   = 8'd5;

   typedef enum logic [2:0] {
      PH_CODE  = 3'd0,
      PH_LEN   = 3'd1,
      PH_VALUE = 3'd2,
      PH_END   = 3'd3
   } opt_phase_type;

   typedef struct packed {
      logic [7:0]  message_type;
      logic [31:0] server_address;
      logic [31:0] subnet_mask;
      logic [31:0] gateway_address;
      logic [31:0] dns_address;
   } lease_type;

   typedef struct packed {
      logic mismatch;
      logic yiaddr_capture;
   } hdr_status_type;

   typedef struct packed {
      logic        accepted;
      logic [7:0]  message_type;
      logic [31:0] offered_address;
      logic [31:0] server_address;
      logic [31:0] subnet_mask;
      logic [31:0] gateway_address;
      logic [31:0] dns_address;
   } result_type;

endpackage

// File: hw/rtl/dhcprp_req_if.sv
// ----------------------------------------------------------------------------
// dhcprp_req_if
// Byte request channel: one datagram byte with its last-byte mark.
// ----------------------------------------------------------------------------
interface dhcprp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/dhcprp_rsp_if.sv
// ----------------------------------------------------------------------------
// dhcprp_rsp_if
// Result channel: verdict and extracted addresses for one datagram.
// ----------------------------------------------------------------------------
interface dhcprp_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [7:0]  message_type;
   logic [31:0] offered_address;
   logic [31:0] server_address;
   logic [31:0] subnet_mask;
   logic [31:0] gateway_address;
   logic [31:0] dns_address;

   modport source (output valid, output accepted, output message_type,
                   output offered_address, output server_address,
                   output subnet_mask, output gateway_address,
                   output dns_address, input ready);
   modport sink   (input valid, input accepted, input message_type,
                   input offered_address, input server_address,
                   input subnet_mask, input gateway_address,
                   input dns_address, output ready);
endinterface

// File: hw/rtl/dhcprp_header.sv
// ----------------------------------------------------------------------------
// dhcprp_header
// Compares one header byte against the value expected at its offset and
// flags the bytes that carry yiaddr.
// ----------------------------------------------------------------------------
module dhcprp_header #(
   parameter int COUNT_BITS    = dhcprp_pkg::COUNT_BITS_DEFAULT,
   parameter int HW_ADDR_BYTES = dhcprp_pkg::HW_ADDR_BYTES_DEFAULT
) (
   input  logic [COUNT_BITS-1:0]           byte_index,
   input  logic [7:0]                      data_byte,
   input  logic [31:0]                     client_xid,
   input  logic [47:0]                     client_mac,
   output dhcprp_pkg::hdr_status_type      status
);

   logic [63:0]           mac_wide;
   logic [COUNT_BITS-1:0] mac_offset;
   logic [2:0]            mac_sel;
   logic [1:0]            lane_sel;
   logic [7:0]            want;
   logic                  test;

   assign mac_wide   = {16'h0, client_mac};
   assign mac_offset = byte_index - COUNT_BITS'(dhcprp_pkg::CHADDR_FIRST);
   // first chaddr byte pairs with the most significant configured byte
   assign mac_sel    = 3'(HW_ADDR_BYTES - 1) - mac_offset[2:0];
   // byte lane of a big-endian word that starts on a multiple of four
   assign lane_sel   = ~byte_index[1:0];

   always_comb begin
      want = data_byte;
      test = 1'b1;
      if (byte_index == COUNT_BITS'(dhcprp_pkg::SRC_PORT_HI)) begin
         want = 8'h00;
      end else if (byte_index == COUNT_BITS'(dhcprp_pkg::SRC_PORT_LO)) begin
         want = dhcprp_pkg::SERVER_PORT;
      end else if (byte_index == COUNT_BITS'(dhcprp_pkg::DST_PORT_HI)) begin
         want = 8'h00;
      end else if (byte_index == COUNT_BITS'(dhcprp_pkg::DST_PORT_LO)) begin
         want = dhcprp_pkg::CLIENT_PORT;
      end else if (byte_index == COUNT_BITS'(dhcprp_pkg::OP_OFFSET)) begin
         want = dhcprp_pkg::BOOTREPLY;
      end else if (byte_index >= COUNT_BITS'(dhcprp_pkg::XID_FIRST) &&
                   byte_index <= COUNT_BITS'(dhcprp_pkg::XID_LAST)) begin
         want = client_xid[8*lane_sel +: 8];
      end else if (byte_index >= COUNT_BITS'(dhcprp_pkg::COOKIE_FIRST) &&
                   byte_index <= COUNT_BITS'(dhcprp_pkg::COOKIE_LAST)) begin
         want = dhcprp_pkg::MAGIC_COOKIE[8*lane_sel +: 8];
      end else if (byte_index >= COUNT_BITS'(dhcprp_pkg::CHADDR_FIRST) &&
                   byte_index < COUNT_BITS'(dhcprp_pkg::CHADDR_FIRST + HW_ADDR_BYTES)) begin
         want = mac_wide[8*mac_sel +: 8];
      end else begin
         test = 1'b0;
      end
   end

   assign status.mismatch       = test && (want != data_byte);
   assign status.yiaddr_capture =
      byte_index >= COUNT_BITS'(dhcprp_pkg::YIADDR_FIRST) &&
      byte_index <= COUNT_BITS'(dhcprp_pkg::YIADDR_LAST);

endmodule

// File: hw/rtl/dhcprp_options.sv
// ----------------------------------------------------------------------------
// dhcprp_options
// Option walker: tracks code, length and value of the option under way and
// keeps the lease fields taken from complete options.
// ----------------------------------------------------------------------------
module dhcprp_options (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  clear,
   input  logic [7:0]            data_byte,
   output dhcprp_pkg::lease_type lease_next
);

   dhcprp_pkg::opt_phase_type phase_ff, phase_in;
   logic [7:0]                code_ff, code_in;
   logic [7:0]                length_ff, length_in;
   logic [7:0]                offset_ff, offset_in;
   logic [31:0]               value_ff, value_in;
   dhcprp_pkg::lease_type     lease_ff, lease_in;

   logic        finish;
   logic [1:0]  type_sel;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      finish   = 1'b0;
      if (step) begin
         case (phase_ff)
            dhcprp_pkg::PH_CODE: begin
               if (data_byte == dhcprp_pkg::OPT_END) begin
                  phase_in = dhcprp_pkg::PH_END;
               end else if (data_byte != dhcprp_pkg::OPT_PAD) begin
                  phase_in = dhcprp_pkg::PH_LEN;
               end
            end
            dhcprp_pkg::PH_LEN: begin
               if (data_byte == 8'd0) begin
                  // empty option completes at once with no effect
                  phase_in = dhcprp_pkg::PH_CODE;
               end else begin
                  phase_in = dhcprp_pkg::PH_VALUE;
               end
            end
            dhcprp_pkg::PH_VALUE: begin
               if (offset_in >= length_ff) begin
                  phase_in = dhcprp_pkg::PH_CODE;
                  finish   = 1'b1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // option fields
   always_comb begin
      code_in   = code_ff;
      length_in = length_ff;
      offset_in = offset_ff;
      value_in  = value_ff;
      if (step) begin
         case (phase_ff)
            dhcprp_pkg::PH_CODE: begin
               if (data_byte != dhcprp_pkg::OPT_END && data_byte != dhcprp_pkg::OPT_PAD) begin
                  code_in = data_byte;
               end
            end
            dhcprp_pkg::PH_LEN: begin
               length_in = data_byte;
               offset_in = 8'd0;
               value_in  = 32'd0;
            end
            dhcprp_pkg::PH_VALUE: begin
               if (offset_ff < 8'd4) begin
                  value_in = {value_ff[23:0], data_byte};
               end
               offset_in = offset_ff + 8'd1;
            end
            default: begin
               code_in = code_ff;
            end
         endcase
      end
   end

   // byte that holds the message type: the first of at most four kept
   assign type_sel = (length_ff >= 8'd4) ? 2'd3 : 2'(length_ff - 8'd1);

   // lease fields
   always_comb begin
      lease_in = lease_ff;
      if (finish) begin
         if (code_ff == dhcprp_pkg::OPT_MSG_TYPE) begin
            lease_in.message_type = value_in[8*type_sel +: 8];
         end else if (length_ff >= 8'd4) begin
            case (code_ff)
               dhcprp_pkg::OPT_SERVER: lease_in.server_address  = value_in;
               dhcprp_pkg::OPT_MASK:   lease_in.subnet_mask     = value_in;
               dhcprp_pkg::OPT_ROUTER: lease_in.gateway_address = value_in;
               dhcprp_pkg::OPT_DNS:    lease_in.dns_address     = value_in;
               default:                lease_in = lease_ff;
            endcase
         end
      end
   end

   assign lease_next = lease_in;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff  <= dhcprp_pkg::PH_CODE;
         code_ff   <= 8'd0;
         length_ff <= 8'd0;
         offset_ff <= 8'd0;
         value_ff  <= 32'd0;
         lease_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         code_ff   <= code_in;
         length_ff <= length_in;
         offset_ff <= offset_in;
         value_ff  <= value_in;
         lease_ff  <= lease_in;
      end
   end

endmodule

// File: hw/rtl/dhcp_reply_parser.sv
// ----------------------------------------------------------------------------
// dhcp_reply_parser
// Checks a received DHCP reply byte by byte and extracts the lease fields.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_ch   in   valid/ready    data_byte[7:0], last_byte
//  rsp_ch   out  valid/ready    accepted, message_type, offered_address,
//                               server_address, subnet_mask,
//                               gateway_address, dns_address
//  csr_*    in   write enable   csr_index (0 client_xid, 1 client_mac)
//
//  One byte is accepted every cycle; the result for a datagram appears in
//  the result register the cycle after its last byte is accepted.
//  Non-last bytes are taken while a result waits; a last byte stalls only
//  while the result register is full and rsp_ch is not ready.
//  Synchronous reset clears all per-datagram state but the result register
//  and loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dhcp_reply_parser #(
   parameter int COUNT_BITS    = dhcprp_pkg::COUNT_BITS_DEFAULT,
   parameter int HW_ADDR_BYTES = dhcprp_pkg::HW_ADDR_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   dhcprp_req_if.sink                          req_ch,
   dhcprp_rsp_if.source                        rsp_ch,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [dhcprp_pkg::CSR_DATA_BITS-1:0] csr_write_data
);

   logic [31:0]            xid_ff;
   logic [47:0]            mac_ff;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   good_ff, good_in;
   logic [31:0]            yiaddr_ff, yiaddr_in;
   logic                   rsp_valid_ff;
   dhcprp_pkg::result_type result_ff, result_in;

   dhcprp_pkg::hdr_status_type hdr_status;
   dhcprp_pkg::lease_type      lease_next;

   logic accept;
   logic finish;
   logic in_header;
   logic type_ok;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready || !req_ch.last_byte;
   assign accept       = req_ch.valid && req_ch.ready;
   assign finish       = accept && req_ch.last_byte;
   assign in_header    = count_ff < COUNT_BITS'(dhcprp_pkg::OPT_START);

   dhcprp_header #(
      .COUNT_BITS    (COUNT_BITS),
      .HW_ADDR_BYTES (HW_ADDR_BYTES)
   ) u_header (
      .byte_index (count_ff),
      .data_byte  (req_ch.data_byte),
      .client_xid (xid_ff),
      .client_mac (mac_ff),
      .status     (hdr_status)
   );

   dhcprp_options u_options (
      .clock      (clock),
      .reset      (reset),
      .step       (accept && !in_header),
      .clear      (finish),
      .data_byte  (req_ch.data_byte),
      .lease_next (lease_next)
   );

   always_comb begin
      good_in   = good_ff;
      yiaddr_in = yiaddr_ff;
      count_in  = count_ff;
      if (accept) begin
         if (in_header && hdr_status.mismatch) begin
            good_in = 1'b0;
         end
         if (in_header && hdr_status.yiaddr_capture) begin
            yiaddr_in = {yiaddr_ff[23:0], req_ch.data_byte};
         end
         // saturate
         if (count_ff != {COUNT_BITS{1'b1}}) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   assign type_ok = lease_next.message_type == dhcprp_pkg::MSG_OFFER ||
                    lease_next.message_type == dhcprp_pkg::MSG_ACK;

   always_comb begin
      result_in = '0;
      if (good_in && type_ok &&
          count_ff >= COUNT_BITS'(dhcprp_pkg::OPT_START - 1)) begin
         result_in.accepted        = 1'b1;
         result_in.message_type    = lease_next.message_type;
         result_in.offered_address = yiaddr_in;
         result_in.server_address  = lease_next.server_address;
         result_in.subnet_mask     = lease_next.subnet_mask;
         result_in.gateway_address = lease_next.gateway_address;
         result_in.dns_address     = lease_next.dns_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         count_ff  <= '0;
         good_ff   <= 1'b1;
         yiaddr_ff <= 32'd0;
      end else begin
         count_ff  <= count_in;
         good_ff   <= good_in;
         yiaddr_ff <= yiaddr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xid_ff <= dhcprp_pkg::CLIENT_XID_RESET;
         mac_ff <= dhcprp_pkg::CLIENT_MAC_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            dhcprp_pkg::CSR_CLIENT_XID: xid_ff <= csr_write_data[31:0];
            dhcprp_pkg::CSR_CLIENT_MAC: mac_ff <= csr_write_data[47:0];
            default:                    xid_ff <= xid_ff;
         endcase
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.accepted        = result_ff.accepted;
   assign rsp_ch.message_type    = result_ff.message_type;
   assign rsp_ch.offered_address = result_ff.offered_address;
   assign rsp_ch.server_address  = result_ff.server_address;
   assign rsp_ch.subnet_mask     = result_ff.subnet_mask;
   assign rsp_ch.gateway_address = result_ff.gateway_address;
   assign rsp_ch.dns_address     = result_ff.dns_address;

endmodule

// File: tb/dhcp_reply_parser_tb.sv
// ----------------------------------------------------------------------------
// dhcp_reply_parser_tb
// Self-checking bench for the DHCP reply parser. Streams whole datagrams byte
// by byte, tracks the parser state in a local predictor, and compares every
// verdict with the predicted one. Covers header checks, the option walk,
// datagram lengths, counter saturation and both client registers.
// ----------------------------------------------------------------------------
module dhcp_reply_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dhcprp_pkg::*;

   localparam int MAC_BYTES     = HW_ADDR_BYTES_DEFAULT;
   localparam int COUNT_MAX     = (1 << COUNT_BITS_DEFAULT) - 1;
   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 4;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic                     csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   dhcprp_req_if req_ch ();
   dhcprp_rsp_if rsp_ch ();

   dhcp_reply_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // local copy of the client registers
   logic [31:0] xid_reg = CLIENT_XID_RESET;
   logic [47:0] mac_reg = CLIENT_MAC_RESET;

   // per-datagram parser state
   int unsigned   rx_count;
   bit            hdr_ok;
   opt_phase_type phase;
   logic [7:0]    opt_code;
   logic [7:0]    opt_len;
   logic [7:0]    opt_off;
   logic [31:0]   opt_val;
   logic [7:0]    seen_type;
   logic [31:0]   yiaddr;
   logic [31:0]   seen_server;
   logic [31:0]   seen_mask;
   logic [31:0]   seen_router;
   logic [31:0]   seen_dns;

   result_type expected_verdicts[$];
   logic [7:0] frame[$];
   int         checked_idx[$];
   bit         quiet = 1'b0;
   int         errors = 0;
   int         idle_cycles = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Expected value of a header byte; fill is returned where nothing is checked.
   function automatic logic [7:0] header_byte(int idx, logic [7:0] fill, output bit checked);
      logic [31:0] cookie;
      cookie  = MAGIC_COOKIE;
      checked = 1'b1;
      if (idx == SRC_PORT_HI || idx == DST_PORT_HI) return 8'h00;
      if (idx == SRC_PORT_LO) return SERVER_PORT;
      if (idx == DST_PORT_LO) return CLIENT_PORT;
      if (idx == OP_OFFSET) return BOOTREPLY;
      if (idx >= XID_FIRST && idx <= XID_LAST) return xid_reg[8*(XID_LAST-idx) +: 8];
      if (idx >= COOKIE_FIRST && idx <= COOKIE_LAST) return cookie[8*(COOKIE_LAST-idx) +: 8];
      if (idx >= CHADDR_FIRST && idx < CHADDR_FIRST + MAC_BYTES)
         return mac_reg[8*(MAC_BYTES-1-(idx-CHADDR_FIRST)) +: 8];
      checked = 1'b0;
      return fill;
   endfunction

   function automatic void restart_datagram();
      rx_count    = 0;
      hdr_ok      = 1'b1;
      phase       = PH_CODE;
      opt_code    = '0;
      opt_len     = '0;
      opt_off     = '0;
      opt_val     = '0;
      seen_type   = '0;
      yiaddr      = '0;
      seen_server = '0;
      seen_mask   = '0;
      seen_router = '0;
      seen_dns    = '0;
   endfunction

   function automatic void close_option();
      int n;
      n = (opt_len < 8'd4) ? int'(opt_len) : 4;
      if (opt_code == OPT_MSG_TYPE && n >= 1) begin
         seen_type = opt_val[8*(n-1) +: 8];
      end else if (opt_len >= 8'd4) begin
         case (opt_code)
            OPT_SERVER: seen_server = opt_val;
            OPT_MASK:   seen_mask   = opt_val;
            OPT_ROUTER: seen_router = opt_val;
            OPT_DNS:    seen_dns    = opt_val;
            default: ;
         endcase
      end
      phase = PH_CODE;
   endfunction

   // Advance the parser state by one accepted byte; queue a verdict on the last.
   function automatic void parse_reply_byte(logic [7:0] b, logic last);
      int         idx;
      bit         checked;
      logic [7:0] want;
      result_type verdict;
      idx = rx_count;
      if (idx < OPT_START) begin
         want = header_byte(idx, b, checked);
         if (checked && want != b) hdr_ok = 1'b0;
         if (idx >= YIADDR_FIRST && idx <= YIADDR_LAST) yiaddr = {yiaddr[23:0], b};
      end else begin
         case (phase)
            PH_CODE: begin
               if (b == OPT_END) begin
                  phase = PH_END;
               end else if (b != OPT_PAD) begin
                  opt_code = b;
                  phase    = PH_LEN;
               end
            end
            PH_LEN: begin
               opt_len = b;
               opt_off = '0;
               opt_val = '0;
               if (b == 8'd0) close_option();
               else phase = PH_VALUE;
            end
            PH_VALUE: begin
               if (opt_off < 8'd4) opt_val = {opt_val[23:0], b};
               opt_off = opt_off + 8'd1;
               if (opt_off >= opt_len) close_option();
            end
            default: ;
         endcase
      end
      if (rx_count < COUNT_MAX) rx_count++;
      if (last) begin
         verdict = '0;
         if (hdr_ok && idx >= OPT_START - 1 && (seen_type == MSG_OFFER || seen_type == MSG_ACK))
         begin
            verdict.accepted        = 1'b1;
            verdict.message_type    = seen_type;
            verdict.offered_address = yiaddr;
            verdict.server_address  = seen_server;
            verdict.subnet_mask     = seen_mask;
            verdict.gateway_address = seen_router;
            verdict.dns_address     = seen_dns;
         end
         expected_verdicts.push_back(verdict);
         restart_datagram();
      end
   endfunction

   // Build a well-formed header; corrupt_at names a byte to spoil, -1 for none.
   function automatic void start_reply(logic [31:0] yi, int corrupt_at);
      int         i;
      bit         chk;
      logic [7:0] b;
      frame.delete();
      for (i = 0; i < OPT_START; i++) begin
         b = header_byte(i, 8'($urandom), chk);
         if (i >= YIADDR_FIRST && i <= YIADDR_LAST) b = yi[8*(YIADDR_LAST-i) +: 8];
         if (i == corrupt_at) b ^= 8'($urandom_range(1, 255));
         frame.push_back(b);
      end
   endfunction

   // The first min(len, 4) value bytes carry the low bytes of val, first byte most significant.
   function automatic void add_option(logic [7:0] code, int len, logic [31:0] val);
      int n;
      int i;
      n = (len < 4) ? len : 4;
      frame.push_back(code);
      frame.push_back(8'(len));
      for (i = 0; i < len; i++)
         frame.push_back((i < n) ? val[8*(n-1-i) +: 8] : 8'($urandom));
   endfunction

   function automatic void random_option();
      int          pick;
      int          len;
      int          n;
      logic [7:0]  code;
      logic [31:0] val;
      pick = $urandom_range(0, 19);
      val  = $urandom;
      if (pick < 6) begin
         code = OPT_MSG_TYPE;
         len  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 6) : 1;
         n    = (len < 4) ? len : 4;
         if (n > 0 && $urandom_range(0, 9) != 0)
            val[8*(n-1) +: 8] = $urandom_range(0, 1) ? MSG_OFFER : MSG_ACK;
      end else if (pick < 18) begin
         case (pick % 4)
            0: code = OPT_SERVER;
            1: code = OPT_MASK;
            2: code = OPT_ROUTER;
            default: code = OPT_DNS;
         endcase
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : 4;
      end else if (pick == 18) begin
         repeat ($urandom_range(1, 4)) frame.push_back(OPT_PAD);
         return;
      end else begin
         code = 8'($urandom);
         len  = $urandom_range(0, 12);
      end
      add_option(code, len, val);
   endfunction

   function automatic void random_reply();
      int kind;
      int cut;
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
         frame.delete();
         repeat ($urandom_range(1, 300)) frame.push_back(8'($urandom));
         return;
      end
      start_reply($urandom,
                  (kind == 1) ? checked_idx[$urandom_range(0, checked_idx.size() - 1)] : -1);
      repeat ($urandom_range(1, 7)) random_option();
      if ($urandom_range(0, 5) == 0) begin
         frame.push_back(OPT_END);
         repeat ($urandom_range(0, 10)) frame.push_back(8'($urandom));
      end
      if (kind == 2) begin
         cut = $urandom_range(1, OPT_START - 1);
         while (frame.size() > cut) void'(frame.pop_back());
      end else if ($urandom_range(0, 7) == 0) begin
         // drop the tail, usually in the middle of an option
         repeat ($urandom_range(1, 6))
            if (frame.size() > OPT_START) void'(frame.pop_back());
      end
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      if (!quiet && $urandom_range(0, 15) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      parse_reply_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
   endtask

   // Hold off until every verdict is in and the result register has settled.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_CLIENT_XID) xid_reg = data[31:0];
      else mac_reg = data[47:0];
      @(negedge clock);
   endtask

   task automatic send_lease_reply(logic [7:0] msg, int corrupt_at);
      start_reply($urandom, corrupt_at);
      add_option(OPT_MSG_TYPE, 1, {24'h0, msg});
      add_option(OPT_SERVER, 4, $urandom);
      add_option(OPT_MASK, 4, $urandom);
      add_option(OPT_ROUTER, 4, $urandom);
      add_option(OPT_DNS, 4, $urandom);
      frame.push_back(OPT_END);
      send_frame();
   endtask

   task automatic test_reset_values();
      send_lease_reply(MSG_OFFER, -1);
      send_lease_reply(MSG_ACK, -1);
      drain();
   endtask

   task automatic test_header_checks();
      foreach (checked_idx[k]) send_lease_reply(MSG_ACK, checked_idx[k]);
      drain();
   endtask

   task automatic test_datagram_lengths();
      frame.delete();
      frame.push_back(8'($urandom));
      send_frame();
      // one byte short of the minimum
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      while (frame.size() > OPT_START - 1) void'(frame.pop_back());
      send_frame();
      // header only: no message type
      start_reply($urandom, -1);
      send_frame();
      // type option completes on the last byte
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      send_frame();
      // end option right at the first option byte
      start_reply($urandom, -1);
      frame.push_back(OPT_END);
      send_frame();
      drain();
   endtask

   task automatic test_option_walk();
      // every recorded option, pads between, bytes after end are ignored
      start_reply($urandom, -1);
      frame.push_back(OPT_PAD);
      add_option(OPT_MSG_TYPE, 1, MSG_OFFER);
      frame.push_back(OPT_PAD);
      frame.push_back(OPT_PAD);
      add_option(OPT_SERVER, 4, $urandom);
      add_option(OPT_MASK, 4, 32'hFFFF_FF00);
      add_option(OPT_ROUTER, 8, $urandom);
      add_option(OPT_DNS, 12, $urandom);
      frame.push_back(OPT_END);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      add_option(OPT_SERVER, 4, $urandom);
      send_frame();
      // repeated options: the later one wins
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_OFFER);
      add_option(OPT_SERVER, 4, $urandom);
      add_option(OPT_DNS, 4, $urandom);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      add_option(OPT_SERVER, 4, $urandom);
      add_option(OPT_DNS, 4, $urandom);
      send_frame();
      // short values are skipped, as is a type of length zero
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      add_option(OPT_SERVER, 3, $urandom);
      add_option(OPT_MASK, 0, 32'h0);
      add_option(OPT_ROUTER, 2, $urandom);
      add_option(OPT_DNS, 1, $urandom);
      add_option(OPT_MSG_TYPE, 0, 32'h0);
      send_frame();
      // type taken from the first value byte of a longer option
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 3, {8'h00, MSG_ACK, 8'h11, 8'h22});
      add_option(OPT_MSG_TYPE, 6, {MSG_OFFER, 24'h05_0505});
      send_frame();
      // types other than offer and ack are refused
      send_lease_reply(8'd1, -1);
      send_lease_reply(8'd3, -1);
      send_lease_reply(8'hFF, -1);
      send_lease_reply(8'h00, -1);
      // option cut off by the last byte inside its value
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      add_option(OPT_SERVER, 4, $urandom);
      void'(frame.pop_back());
      void'(frame.pop_back());
      send_frame();
      // last byte on an option code, then on a length
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_OFFER);
      frame.push_back(OPT_MASK);
      send_frame();
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_OFFER);
      frame.push_back(OPT_MASK);
      frame.push_back(8'd4);
      send_frame();
      // truncated type option leaves no type
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      void'(frame.pop_back());
      send_frame();
      // unknown codes, one empty and one long enough to swallow option bytes
      start_reply($urandom, -1);
      add_option(8'd77, 0, 32'h0);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      add_option(8'd200, 255, $urandom);
      add_option(OPT_DNS, 4, $urandom);
      send_frame();
      // field extremes
      start_reply(32'hFFFF_FFFF, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      add_option(OPT_SERVER, 4, 32'hFFFF_FFFF);
      add_option(OPT_MASK, 4, 32'hFFFF_FFFF);
      add_option(OPT_ROUTER, 4, 32'hFFFF_FFFF);
      add_option(OPT_DNS, 4, 32'hFFFF_FFFF);
      send_frame();
      start_reply(32'h0, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_OFFER);
      add_option(OPT_SERVER, 4, 32'h0);
      add_option(OPT_MASK, 4, 32'h0);
      add_option(OPT_ROUTER, 4, 32'h0);
      add_option(OPT_DNS, 4, 32'h0);
      send_frame();
      drain();
   endtask

   // Run the byte counter into saturation; the option walk must keep going.
   task automatic test_long_datagram();
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      repeat (COUNT_MAX - OPT_START + 130) frame.push_back(OPT_PAD);
      add_option(OPT_SERVER, 4, $urandom);
      add_option(OPT_MASK, 4, $urandom);
      send_frame();
      drain();
   endtask

   task automatic test_register_extremes();
      write_csr(CSR_CLIENT_XID, '0);
      write_csr(CSR_CLIENT_MAC, '0);
      send_lease_reply(MSG_OFFER, -1);
      send_lease_reply(MSG_ACK, XID_FIRST);
      drain();
      write_csr(CSR_CLIENT_XID, '1);
      write_csr(CSR_CLIENT_MAC, '1);
      send_lease_reply(MSG_ACK, -1);
      send_lease_reply(MSG_OFFER, CHADDR_FIRST + MAC_BYTES - 1);
      drain();
      // a reply built for the old registers must be refused after a change
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_ACK);
      write_csr(CSR_CLIENT_XID, {16'($urandom), xid_reg ^ (32'd1 << $urandom_range(0, 31))});
      send_frame();
      drain();
      start_reply($urandom, -1);
      add_option(OPT_MSG_TYPE, 1, MSG_OFFER);
      write_csr(CSR_CLIENT_MAC, mac_reg ^ (48'd1 << $urandom_range(0, 47)));
      send_frame();
      drain();
      send_lease_reply(MSG_ACK, -1);
      drain();
   endtask

   task automatic test_random_traffic(int phases, int per_phase, bit calm);
      repeat (phases) begin
         write_csr(CSR_CLIENT_XID, {16'($urandom), 32'($urandom)});
         write_csr(CSR_CLIENT_MAC, {16'($urandom), 32'($urandom)});
         repeat (per_phase) begin
            quiet = calm || ($urandom_range(0, 3) == 0);
            random_reply();
            send_frame();
         end
         drain();
      end
   endtask

   // Random stalls on the result side.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch: expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t ns: result with no datagram pending: accepted %b, type %h",
                     $time, rsp_ch.accepted, rsp_ch.message_type);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("accepted", want.accepted, rsp_ch.accepted);
            check_field("message_type", want.message_type, rsp_ch.message_type);
            check_field("offered_address", want.offered_address, rsp_ch.offered_address);
            check_field("server_address", want.server_address, rsp_ch.server_address);
            check_field("subnet_mask", want.subnet_mask, rsp_ch.subnet_mask);
            check_field("gateway_address", want.gateway_address, rsp_ch.gateway_address);
            check_field("dns_address", want.dns_address, rsp_ch.dns_address);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("** dhcp_reply_parser: FAILED **");
         $finish;
      end
   end

   initial begin
      int         i;
      bit         chk;
      logic [7:0] probe;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_CLIENT_XID;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      restart_datagram();
      for (i = 0; i < OPT_START; i++) begin
         probe = header_byte(i, 8'h00, chk);
         if (chk) checked_idx.push_back(i);
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_header_checks();
      test_datagram_lengths();
      test_option_walk();
      test_long_datagram();
      test_register_extremes();
      test_random_traffic(4, 12, 1'b0);
      test_random_traffic(1, 8, 1'b1);
      drain();

      if (errors == 0)
         $display("** dhcp_reply_parser: PASSED **");
      else
         $display("** dhcp_reply_parser: FAILED **");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/dhcprp_pkg.sv
hw/rtl/dhcprp_req_if.sv
hw/rtl/dhcprp_rsp_if.sv
hw/rtl/dhcprp_header.sv
hw/rtl/dhcprp_options.sv
hw/rtl/dhcp_reply_parser.sv
tb/dhcp_reply_parser_tb.sv
